/* src/nearest_anchor_hover_test_unit_assert.svh */
// Assertion macros for the hover test unit checker.
`ifndef NEAREST_ANCHOR_HOVER_TEST_UNIT_ASSERT_SVH
`define NEAREST_ANCHOR_HOVER_TEST_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define NAHTU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define NAHTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/nahtu_pkg.sv */
// Package: types and constants of the nearest anchor hover test unit.
package nahtu_pkg;

  localparam int CoordW = 16;
  localparam int IdxOutW = 6;
  localparam int CfgW = 7;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_MOVE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RSQ,
    ST_DONE
  } state_t;

endpackage

/* src/nearest_anchor_hover_test_unit.sv */
// Top level: anchor table with a sequenced nearest-anchor hover test.
//
// Usage:
//  - Input words are taken on a rising edge with start high and busy low.
//    in_command selects a load (write one anchor entry: centre in_pos_x/y,
//    in_entry_radius at in_entry_index) or a move (pointer at in_pos_x/y).
//  - A load is written in the accept cycle, gives no result and leaves busy
//    low, so loads can stream one per cycle. Indexes beyond the table drop.
//  - A move scans entries 0..anchor_count-1 (count saturates at MAX_ANCHORS)
//    through one distance datapath, one entry per cycle: table read, abs
//    difference, square, sum and running minimum. Busy stays high through
//    the scan, drain, radius-square and done states (only the done state
//    with an empty table). Result word: out_valid strobes for one cycle
//    as busy falls; the receiver cannot stall it.
//  - cfg_anchor_count is written when cfg_valid and cfg_ready are high;
//    cfg_ready is always high, and writes belong in idle time only.
//  - Reset (rst_n low, synchronous) clears the sequencer, hover state and
//    anchor_count. The table itself is not cleared; unwritten entries must
//    not be scanned.
module nearest_anchor_hover_test_unit
  import nahtu_pkg::*;
#(
  parameter int MAX_ANCHORS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_command,
  input  logic [5:0]                in_entry_index,
  input  logic signed [CoordW-1:0]  in_pos_x,
  input  logic signed [CoordW-1:0]  in_pos_y,
  input  logic [CoordW-1:0]         in_entry_radius,
  // result channel
  output logic                      out_valid,
  output logic                      out_hit,
  output logic                      out_leave_event,
  output logic [IdxOutW-1:0]        out_leave_index,
  output logic                      out_enter_event,
  output logic                      out_hover_now_valid,
  output logic [IdxOutW-1:0]        out_hover_now_index,
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CfgW-1:0]           cfg_anchor_count
);

  // table address width and a width wide enough for both addresses and
  // the 6-bit index ports
  localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
  localparam int IW = (AW > IdxOutW) ? AW : IdxOutW;
  localparam int CNTW0 = $clog2(MAX_ANCHORS + 1);
  localparam int CW = (CNTW0 > CfgW) ? CNTW0 : CfgW;
  localparam int MW = 3 * CoordW;
  localparam int SQW = 2 * CoordW;
  localparam int DW = SQW + 1;

  // anchor table: {radius, y, x}
  logic [MW-1:0] mem [MAX_ANCHORS];

  state_t state_r, state_nxt;
  logic   issue, do_rsq, do_done;

  logic [CfgW-1:0] count_r;
  logic [CW-1:0]   count_eff;
  logic [IW-1:0]   wr_idx;
  logic            wr_ok;

  logic signed [CoordW-1:0] px_r, py_r;
  logic                     empty_r;
  logic [CW-1:0]            scan_cnt_r;

  // scan pipeline
  logic            v1_r, v2_r, v3_r;
  logic [AW-1:0]   idx1_r, idx2_r, idx3_r;
  logic [MW-1:0]   rd_data_r;
  logic [CoordW-1:0] ax_r, ay_r, rad2_r, rad3_r;
  logic [SQW-1:0]  sqx_r, sqy_r;

  logic signed [CoordW:0] dx, dy;
  logic [CoordW:0]        dx_abs, dy_abs;
  logic [DW-1:0]          sum_d;

  // running minimum
  logic            first_r;
  logic [DW-1:0]   best_d_r;
  logic [AW-1:0]   best_idx_r;
  logic [CoordW-1:0] best_rad_r;
  logic [SQW-1:0]  rsq_r;

  // hover state
  logic          hover_valid_r;
  logic [IW-1:0] hover_idx_r;

  // result word
  logic                out_valid_r, hit_r, leave_r;
  logic [IdxOutW-1:0]  leave_idx_r, now_idx_r;
  logic                now_valid_r;

  logic          res_hit, res_leave;
  logic [IW-1:0] best_idx_w;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // effective count, clipped to the table size
  always_comb begin
    count_eff = CW'(count_r);
    if (CW'(count_r) > CW'(MAX_ANCHORS)) begin
      count_eff = CW'(MAX_ANCHORS);
    end
  end

  // compare one bit wider so a table of 2**IW entries is not truncated away
  assign wr_idx = IW'(in_entry_index);
  assign wr_ok  = ({1'b0, wr_idx} < (IW+1)'(MAX_ANCHORS));

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    issue     = 1'b0;
    do_rsq    = 1'b0;
    do_done   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start && (in_command == CMD_MOVE)) begin
          state_nxt = (count_eff == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (scan_cnt_r == count_eff - CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(v1_r || v2_r || v3_r)) begin
          state_nxt = ST_RSQ;
        end
      end
      ST_RSQ: begin
        do_rsq    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        do_done   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      count_r <= cfg_anchor_count;
    end
  end

  // table write on load, registered read during the scan
  always_ff @(posedge clk) begin
    if (!busy && start && (in_command == CMD_LOAD) && wr_ok) begin
      mem[wr_idx[AW-1:0]] <= {in_entry_radius, in_pos_y, in_pos_x};
    end
    if (issue) begin
      rd_data_r <= mem[scan_cnt_r[AW-1:0]];
    end
  end

  // query capture and scan counter
  always_ff @(posedge clk) begin
    if (!busy && start && (in_command == CMD_MOVE)) begin
      px_r       <= in_pos_x;
      py_r       <= in_pos_y;
      empty_r    <= (count_eff == '0);
      scan_cnt_r <= '0;
    end else if (issue) begin
      scan_cnt_r <= scan_cnt_r + CW'(1);
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: absolute differences
  assign dx = $signed({rd_data_r[CoordW-1], rd_data_r[CoordW-1:0]})
            - $signed({px_r[CoordW-1], px_r});
  assign dy = $signed({rd_data_r[2*CoordW-1], rd_data_r[2*CoordW-1:CoordW]})
            - $signed({py_r[CoordW-1], py_r});
  assign dx_abs = dx[CoordW] ? (CoordW+1)'(-dx) : (CoordW+1)'(dx);
  assign dy_abs = dy[CoordW] ? (CoordW+1)'(-dy) : (CoordW+1)'(dy);

  always_ff @(posedge clk) begin
    idx1_r <= scan_cnt_r[AW-1:0];
    // |d| never exceeds 16 bits
    ax_r   <= dx_abs[CoordW-1:0];
    ay_r   <= dy_abs[CoordW-1:0];
    rad2_r <= rd_data_r[MW-1:2*CoordW];
    idx2_r <= idx1_r;
    // stage 2: squares
    sqx_r  <= ax_r * ax_r;
    sqy_r  <= ay_r * ay_r;
    rad3_r <= rad2_r;
    idx3_r <= idx2_r;
  end

  // stage 3: sum and running minimum, strict compare keeps lowest index
  assign sum_d = DW'(sqx_r) + DW'(sqy_r);

  always_ff @(posedge clk) begin
    if (!busy && start && (in_command == CMD_MOVE)) begin
      first_r <= 1'b1;
    end else if (v3_r) begin
      first_r <= 1'b0;
      if (first_r || (sum_d < best_d_r)) begin
        best_d_r   <= sum_d;
        best_idx_r <= idx3_r;
        best_rad_r <= rad3_r;
      end
    end
    if (do_rsq) begin
      rsq_r <= best_rad_r * best_rad_r;
    end
  end

  // decision
  assign best_idx_w = IW'(best_idx_r);
  assign res_hit    = (best_d_r < DW'(rsq_r));
  assign res_leave  = hover_valid_r && (hover_idx_r != best_idx_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hover_valid_r <= 1'b0;
      hover_idx_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= do_done;
      if (do_done && !empty_r) begin
        hover_valid_r <= res_hit;
        hover_idx_r   <= res_hit ? best_idx_w : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_done) begin
      if (empty_r) begin
        // empty table: miss, hover reported as it stands
        hit_r       <= 1'b0;
        leave_r     <= 1'b0;
        leave_idx_r <= '0;
        now_valid_r <= hover_valid_r;
        now_idx_r   <= hover_valid_r ? hover_idx_r[IdxOutW-1:0] : '0;
      end else begin
        hit_r       <= res_hit;
        leave_r     <= res_leave;
        leave_idx_r <= res_leave ? hover_idx_r[IdxOutW-1:0] : '0;
        now_valid_r <= res_hit;
        now_idx_r   <= res_hit ? best_idx_w[IdxOutW-1:0] : '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = hit_r;
  assign out_leave_event     = leave_r;
  assign out_leave_index     = leave_idx_r;
  assign out_enter_event     = hit_r;
  assign out_hover_now_valid = now_valid_r;
  assign out_hover_now_index = now_idx_r;

endmodule

/* src/nahtu_checker.sv */
// Port-level checker for the hover test unit, with its bind.
`include "nearest_anchor_hover_test_unit_assert.svh"

module nahtu_checker
  import nahtu_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input logic               out_hit,
  input logic               out_leave_event,
  input logic [IdxOutW-1:0] out_leave_index,
  input logic               out_enter_event,
  input logic               out_hover_now_valid,
  input logic [IdxOutW-1:0] out_hover_now_index
);

  `NAHTU_ASSERT_NOW(a_enter_is_hit, out_valid, out_enter_event == out_hit, "enter differs from hit")
  `NAHTU_ASSERT_NOW(a_hit_hovers, out_valid && out_hit, out_hover_now_valid, "hit without hover")
  `NAHTU_ASSERT_NOW(a_idle_idx_zero, out_valid && !out_hover_now_valid, out_hover_now_index == '0, "hover index not zero")
  `NAHTU_ASSERT_NOW(a_leave_idx_zero, out_valid && !out_leave_event, out_leave_index == '0, "leave index not zero")
  `NAHTU_ASSERT_NOW(a_result_after_busy, $fell(busy), out_valid, "no result after busy")

endmodule

bind nearest_anchor_hover_test_unit nahtu_checker u_nahtu_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_hit             (out_hit),
  .out_leave_event     (out_leave_event),
  .out_leave_index     (out_leave_index),
  .out_enter_event     (out_enter_event),
  .out_hover_now_valid (out_hover_now_valid),
  .out_hover_now_index (out_hover_now_index)
);
